// ===== rtl/btl_pkg.sv =====
// Shared types and constants for the bilinear table lookup block.
`timescale 1ns / 1ps
`default_nettype none
package btl_pkg;

  localparam int CFG_W        = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int BISECT_STEPS = 50;
  localparam int TOL_SHIFT    = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_THP_POINTS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_POINTS = 1'd1;

  localparam logic [2:0] ACT_LOAD_THP  = 3'd0;
  localparam logic [2:0] ACT_LOAD_RATE = 3'd1;
  localparam logic [2:0] ACT_LOAD_GRID = 3'd2;
  localparam logic [2:0] ACT_FORWARD   = 3'd3;
  localparam logic [2:0] ACT_INVERSE   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  typedef enum logic [3:0] {
    K_LOAD_THP,
    K_LOAD_RATE,
    K_LOAD_GRID,
    K_FWD,
    K_INV,
    K_FWD_EMPTY,
    K_INV_EMPTY,
    K_BAD,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  index;
    logic [31:0] value;
    logic [31:0] qt;
    logic [31:0] qr;
    logic [31:0] tgt;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/btl_if.sv =====
// Input and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface btl_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  load_index;
  logic [31:0] load_value;
  logic [31:0] query_thp;
  logic [31:0] query_rate;
  logic [31:0] target_pressure;
  modport source (output valid, action, load_index, load_value, query_thp, query_rate,
                  target_pressure, input ready);
  modport sink (input valid, action, load_index, load_value, query_thp, query_rate,
                target_pressure, output ready);
endinterface

interface btl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic [1:0]  status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/bilinear_table_lookup_with_inverse.sv =====
// Top level: configuration registers, front end queue and lookup engine.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    action, load_index, load_value, query_thp,
//                               query_rate, target_pressure
//  out_ch   out  valid/ready    result_value, status
//  cfg      in   cfg_we         cfg_index, cfg_data (no read-back)
//
// Loads, bad indices and empty-table lookups go straight to the result stage.
// Forward lookup: two bracket scans (one RAM read per cycle), a restoring
// divide of FRACTION_BITS+1 quotient bits per axis where needed, then
// blending in states S_G0 to S_G8 on one shared multiplier.
// Inverse: one thp bracket, then up to 50 rate-bracket-plus-blend passes of
// bisection. One item is in the engine at a time.
// Synchronous reset clears control only; table contents are undefined until
// loaded. A two-entry queue keeps taking input while the engine is busy, and
// the result register lets the engine finish while out_ch stalls.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_table_lookup_with_inverse import btl_pkg::*; #(
  parameter int MAX_THP_POINTS  = 16,
  parameter int MAX_RATE_POINTS = 16,
  parameter int FRACTION_BITS   = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  btl_in_if.sink                    in_ch,
  btl_out_if.source                 out_ch
);
  logic [CFG_W-1:0] thp_points, rate_points;
  logic             cmd_valid, cmd_ready;
  cmd_t             cmd;

  // config registers; to be written only while idle (the block does not enforce this)
  always_ff @(posedge clk) begin
    if (rst) begin
      thp_points  <= '0;
      rate_points <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THP_POINTS:  thp_points  <= cfg_data;
        CFG_RATE_POINTS: rate_points <= cfg_data;
        default: ;
      endcase
    end
  end

  btl_front #(
    .MAX_THP_POINTS(MAX_THP_POINTS), .MAX_RATE_POINTS(MAX_RATE_POINTS)
  ) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .thp_points(thp_points),
    .rate_points(rate_points), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

  btl_back #(
    .MAX_THP_POINTS(MAX_THP_POINTS), .MAX_RATE_POINTS(MAX_RATE_POINTS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .thp_points(thp_points), .rate_points(rate_points), .out_ch(out_ch));
endmodule
`default_nettype wire

// ===== rtl/btl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module btl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/btl_front.sv =====
// Front end: accepts items, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module btl_front import btl_pkg::*; #(
  parameter int MAX_THP_POINTS  = 16,
  parameter int MAX_RATE_POINTS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  btl_in_if.sink                in_ch,
  input  wire logic [CFG_W-1:0] thp_points,
  input  wire logic [CFG_W-1:0] rate_points,
  output logic                  cmd_valid,
  input  wire logic             cmd_ready,
  output cmd_t                  cmd
);
  localparam int GRID_DEPTH = MAX_THP_POINTS * MAX_RATE_POINTS;

  cmd_t       slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  cmd_t       c_new;
  logic       push, pop, empty_tbl;

  assign empty_tbl = (thp_points == '0) || (rate_points == '0);

  always_comb begin
    c_new.index = in_ch.load_index;
    c_new.value = in_ch.load_value;
    c_new.qt    = in_ch.query_thp;
    c_new.qr    = in_ch.query_rate;
    c_new.tgt   = in_ch.target_pressure;
    case (in_ch.action)
      ACT_LOAD_THP:  c_new.kind = (int'(in_ch.load_index) < MAX_THP_POINTS) ? K_LOAD_THP : K_BAD;
      ACT_LOAD_RATE: c_new.kind = (int'(in_ch.load_index) < MAX_RATE_POINTS) ? K_LOAD_RATE : K_BAD;
      ACT_LOAD_GRID: c_new.kind = (int'(in_ch.load_index) < GRID_DEPTH) ? K_LOAD_GRID : K_BAD;
      ACT_FORWARD:   c_new.kind = empty_tbl ? K_FWD_EMPTY : K_FWD;
      ACT_INVERSE:   c_new.kind = empty_tbl ? K_INV_EMPTY : K_INV;
      default:       c_new.kind = K_NOP;
    endcase
  end

  assign in_ch.ready = (count != 2'd2);
  assign cmd_valid   = (count != 2'd0);
  assign cmd         = slot[rd_ptr];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= c_new;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/btl_back.sv =====
// Back end: table storage, bracket search, fraction divider, blend and bisection.
`timescale 1ns / 1ps
`default_nettype none
module btl_back import btl_pkg::*; #(
  parameter int MAX_THP_POINTS  = 16,
  parameter int MAX_RATE_POINTS = 16,
  parameter int FRACTION_BITS   = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire cmd_t             cmd,
  input  wire logic [CFG_W-1:0] thp_points,
  input  wire logic [CFG_W-1:0] rate_points,
  btl_out_if.source             out_ch
);
  localparam int MAXC = (MAX_THP_POINTS > MAX_RATE_POINTS) ? MAX_THP_POINTS : MAX_RATE_POINTS;
  localparam int CW   = $clog2(MAXC + 1);
  localparam int IW   = $clog2(MAXC);
  localparam int TAW  = $clog2(MAX_THP_POINTS);
  localparam int RAW  = $clog2(MAX_RATE_POINTS);
  localparam int GD   = MAX_THP_POINTS * MAX_RATE_POINTS;
  localparam int GAW  = $clog2(GD);
  localparam int FW   = FRACTION_BITS + 1;
  localparam int ACCW = 32 + FRACTION_BITS + 1;
  localparam int DCW  = $clog2(FRACTION_BITS + 1);
  localparam logic [FW-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE, S_B0, S_B1, S_B2, S_B3, S_DIV, S_BDONE, S_LH0, S_LH1, S_LH2, S_MID,
    S_G0, S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_G7, S_G8, S_CHK, S_FIN, S_OUT
  } state_t;

  state_t          state;
  logic [CW-1:0]   nt, nr, n_cur, i, it_p1;
  logic            is_inv, axis;
  logic [31:0]     q, qr_hold, tgt, prev, dsr, lo, hi, r0, r1, vres;
  logic [32:0]     rem, rem_sub;
  logic            rem_ge;
  logic [FW-1:0]   b_frac, quot, tt, tr, mul_b;
  logic [IW-1:0]   b_idx, it, ir, it1, ir1, ax_raddr;
  logic [DCW-1:0]  dcnt;
  logic [5:0]      step;
  logic [ACCW-1:0] acc, prod;
  logic [31:0]     mul_a, pend_value, res_value, mid_calc, err, acc_hi;
  logic [1:0]      pend_status, res_status;
  logic            res_valid, hit;
  logic [31:0]     thp_rdata, rate_rdata, grid_rdata, ax_rd;
  logic [GAW-1:0]  gaddr;
  logic [IW-1:0]   grow, gcol;
  logic            thp_we, rate_we, grid_we;

  // effective point counts
  assign nt = (int'(thp_points) > MAX_THP_POINTS) ? CW'(MAX_THP_POINTS) : CW'(thp_points);
  assign nr = (int'(rate_points) > MAX_RATE_POINTS) ? CW'(MAX_RATE_POINTS) : CW'(rate_points);
  assign n_cur = axis ? nr : nt;
  assign ax_rd = axis ? rate_rdata : thp_rdata;

  assign cmd_ready = (state == S_IDLE);
  assign thp_we  = cmd_valid && cmd_ready && (cmd.kind == K_LOAD_THP);
  assign rate_we = cmd_valid && cmd_ready && (cmd.kind == K_LOAD_RATE);
  assign grid_we = cmd_valid && cmd_ready && (cmd.kind == K_LOAD_GRID);

  always_comb begin
    case (state)
      S_B1:    ax_raddr = IW'(n_cur - CW'(1));
      S_B2:    ax_raddr = IW'(1);
      S_B3:    ax_raddr = IW'(i + CW'(2));
      S_LH1:   ax_raddr = IW'(nr - CW'(1));
      default: ax_raddr = '0;
    endcase
  end

  assign it_p1 = CW'(it) + CW'(1);
  assign it1   = (it_p1 < nt) ? IW'(it_p1) : IW'(nt - CW'(1));
  assign ir1   = ((CW'(ir) + CW'(1)) < nr) ? IW'(CW'(ir) + CW'(1)) : IW'(nr - CW'(1));

  always_comb begin
    case (state)
      S_G1:    begin grow = it;  gcol = ir1; end
      S_G3:    begin grow = it1; gcol = ir;  end
      S_G4:    begin grow = it1; gcol = ir1; end
      default: begin grow = it;  gcol = ir;  end
    endcase
  end
  assign gaddr = GAW'(int'(grow) * int'(nr) + int'(gcol));

  btl_ram #(.WIDTH(32), .DEPTH(MAX_THP_POINTS)) u_thp_ram (
    .clk(clk), .we(thp_we), .waddr(TAW'(cmd.index)), .wdata(cmd.value),
    .raddr(TAW'(ax_raddr)), .rdata(thp_rdata));
  btl_ram #(.WIDTH(32), .DEPTH(MAX_RATE_POINTS)) u_rate_ram (
    .clk(clk), .we(rate_we), .waddr(RAW'(cmd.index)), .wdata(cmd.value),
    .raddr(RAW'(ax_raddr)), .rdata(rate_rdata));
  btl_ram #(.WIDTH(32), .DEPTH(GD)) u_grid_ram (
    .clk(clk), .we(grid_we), .waddr(GAW'(cmd.index)), .wdata(cmd.value),
    .raddr(gaddr), .rdata(grid_rdata));

  // shared blend multiplier
  always_comb begin
    case (state)
      S_G1, S_G4: begin mul_a = grid_rdata; mul_b = FRAC_ONE - tr; end
      S_G2, S_G5: begin mul_a = grid_rdata; mul_b = tr; end
      S_G6:       begin mul_a = r0; mul_b = FRAC_ONE - tt; end
      S_G7:       begin mul_a = r1; mul_b = tt; end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod   = ACCW'(mul_a) * ACCW'(mul_b);
  assign acc_hi = acc[FRACTION_BITS +: 32];

  // one restoring step per cycle
  assign rem_ge  = rem >= {1'b0, dsr};
  assign rem_sub = rem_ge ? (rem - {1'b0, dsr}) : rem;

  assign mid_calc = 32'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign err      = (vres > tgt) ? (vres - tgt) : (tgt - vres);
  assign hit      = {err, {TOL_SHIFT{1'b0}}} < (32 + TOL_SHIFT)'(tgt);

  assign out_ch.valid        = res_valid;
  assign out_ch.result_value = res_value;
  assign out_ch.status       = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && out_ch.ready && state != S_OUT) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            pend_value  <= '0;
            pend_status <= ST_OK;
            q           <= cmd.qt;
            qr_hold     <= cmd.qr;
            tgt         <= cmd.tgt;
            axis        <= 1'b0;
            case (cmd.kind)
              K_FWD:       begin is_inv <= 1'b0; state <= S_B0; end
              K_INV:       begin is_inv <= 1'b1; state <= S_B0; end
              K_BAD:       begin pend_status <= ST_BAD_INDEX; state <= S_OUT; end
              K_FWD_EMPTY: begin
                pend_value  <= cmd.qt;
                pend_status <= ST_EMPTY;
                state       <= S_OUT;
              end
              K_INV_EMPTY: begin pend_status <= ST_EMPTY; state <= S_OUT; end
              default:     state <= S_OUT;
            endcase
          end
        end
        S_B0: state <= S_B1;
        S_B1: begin
          prev <= ax_rd;
          if (n_cur < CW'(2) || q <= ax_rd) begin
            b_idx  <= '0;
            b_frac <= '0;
            state  <= S_BDONE;
          end else begin
            state <= S_B2;
          end
        end
        S_B2: begin
          if (q >= ax_rd) begin
            b_idx  <= IW'(n_cur - CW'(2));
            b_frac <= FRAC_ONE;
            state  <= S_BDONE;
          end else begin
            i     <= '0;
            state <= S_B3;
          end
        end
        S_B3: begin
          if (q >= prev && q <= ax_rd) begin
            b_idx <= IW'(i);
            if (ax_rd == prev) begin
              b_frac <= '0;
              state  <= S_BDONE;
            end else begin
              dsr   <= ax_rd - prev;
              rem   <= {1'b0, q - prev};
              quot  <= '0;
              dcnt  <= '0;
              state <= S_DIV;
            end
          end else if ((i + CW'(2)) < n_cur) begin
            i    <= i + CW'(1);
            prev <= ax_rd;
          end else begin
            // unsorted axis: no bracket found
            b_idx  <= '0;
            b_frac <= '0;
            state  <= S_BDONE;
          end
        end
        S_DIV: begin
          quot <= {quot[FW-2:0], rem_ge};
          rem  <= {rem_sub[31:0], 1'b0};
          dcnt <= dcnt + DCW'(1);
          if (dcnt == DCW'(FRACTION_BITS)) begin
            b_frac <= {quot[FW-2:0], rem_ge};
            state  <= S_BDONE;
          end
        end
        S_BDONE: begin
          if (!axis) begin
            it   <= b_idx;
            tt   <= b_frac;
            axis <= 1'b1;
            if (is_inv) begin
              state <= S_LH0;
            end else begin
              q     <= qr_hold;
              state <= S_B0;
            end
          end else begin
            ir    <= b_idx;
            tr    <= b_frac;
            state <= S_G0;
          end
        end
        S_LH0: state <= S_LH1;
        S_LH1: begin lo <= rate_rdata; state <= S_LH2; end
        S_LH2: begin hi <= rate_rdata; step <= '0; state <= S_MID; end
        S_MID: begin q <= mid_calc; state <= S_B0; end
        S_G0: state <= S_G1;
        S_G1: begin acc <= prod; state <= S_G2; end
        S_G2: begin acc <= acc + prod; state <= S_G3; end
        S_G3: begin r0 <= acc_hi; state <= S_G4; end
        S_G4: begin acc <= prod; state <= S_G5; end
        S_G5: begin acc <= acc + prod; state <= S_G6; end
        S_G6: begin r1 <= acc_hi; acc <= prod; state <= S_G7; end
        S_G7: begin acc <= acc + prod; state <= S_G8; end
        S_G8: begin
          vres <= acc_hi;
          if (is_inv) begin
            state <= S_CHK;
          end else begin
            pend_value <= acc_hi;
            state      <= S_OUT;
          end
        end
        S_CHK: begin
          if (hit) begin
            pend_value <= q;
            state      <= S_OUT;
          end else begin
            if (vres > tgt) hi <= q;
            else            lo <= q;
            if (step == 6'(BISECT_STEPS - 1)) begin
              state <= S_FIN;
            end else begin
              step  <= step + 6'd1;
              state <= S_MID;
            end
          end
        end
        S_FIN: begin pend_value <= mid_calc; state <= S_OUT; end
        S_OUT: begin
          if (!res_valid || out_ch.ready) begin
            res_valid  <= 1'b1;
            res_value  <= pend_value;
            res_status <= pend_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
